@@ hdl/bfsfs_pkg.sv @@
// shared types and constants of the breadth-first first-step finder
package bfsfs_pkg;

   localparam int ROOMS_DEF = 256;
   localparam int DIRS_DEF = 10;
   localparam int HOP_LIMIT = 600;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      ACT_WRITE_EXIT = 2'd0,
      ACT_WRITE_FLAGS = 2'd1,
      ACT_FIRST_STEP = 2'd2,
      ACT_DISTANCE = 2'd3
   } action_type;

   localparam logic [1:0] MODE_PSIONIC = 2'd1;
   localparam logic [1:0] MODE_GOD = 2'd2;

   typedef enum logic [1:0] {
      STS_FOUND = 2'd0,
      STS_ALREADY = 2'd1,
      STS_NO_PATH = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_CLR_MEM,
      ST_IDLE,
      ST_CHECK,
      ST_CLR_VIS,
      ST_SEED,
      ST_EXIT_RD,
      ST_EDGE_RD,
      ST_EDGE_CHK,
      ST_POP_RD,
      ST_POP_DATA,
      ST_RSP_FOUND,
      ST_RSP_ALREADY,
      ST_RSP_NONE
   } state_type;

   typedef struct packed {
      logic       mem_clear;
      logic       cnt_clear;
      logic       vis_clear;
      logic       wr_exit;
      logic       wr_flags;
      logic       load;
      logic       seed;
      logic       exit_rd;
      logic       edge_rd;
      logic       edge_chk;
      logic       level_start;
      logic       pop_rd;
      logic       pop_take;
      logic       rsp_load;
      status_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      logic mem_last;
      logic vis_last;
      logic same;
      logic range_bad;
      logic d_last;
      logic from_src;
      logic queue_empty;
      logic hit;
      logic rsp_free;
   } sts_type;

endpackage

@@ hdl/bfsfs_ctrl.sv @@
// controller state machine of the first-step finder
module bfsfs_ctrl import bfsfs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_action,
   input  sts_type    sts,
   output logic       req_tready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic accept;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR_MEM;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLR_MEM: begin
            if (sts.mem_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && (req_action == ACT_FIRST_STEP || req_action == ACT_DISTANCE)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (sts.same) state_in = ST_RSP_ALREADY;
            else if (sts.range_bad) state_in = ST_RSP_NONE;
            else state_in = ST_CLR_VIS;
         end
         ST_CLR_VIS: begin
            if (sts.vis_last) state_in = ST_SEED;
         end
         ST_SEED: state_in = ST_EXIT_RD;
         ST_EXIT_RD: state_in = ST_EDGE_RD;
         ST_EDGE_RD: state_in = ST_EDGE_CHK;
         ST_EDGE_CHK: begin
            state_in = sts.d_last ? ST_POP_RD : ST_EXIT_RD;
         end
         ST_POP_RD: begin
            state_in = sts.queue_empty ? ST_RSP_NONE : ST_POP_DATA;
         end
         ST_POP_DATA: begin
            state_in = sts.hit ? ST_RSP_FOUND : ST_EXIT_RD;
         end
         ST_RSP_FOUND, ST_RSP_ALREADY, ST_RSP_NONE: begin
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rsp_kind = STS_NO_PATH;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLR_MEM: cmd.mem_clear = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            // ready is high here, so valid alone marks the request
            if (req_tvalid) begin
               unique case (req_action)
                  ACT_WRITE_EXIT: cmd.wr_exit = 1'b1;
                  ACT_WRITE_FLAGS: cmd.wr_flags = 1'b1;
                  default: cmd.load = 1'b1;
               endcase
            end
         end
         ST_CHECK: cmd.cnt_clear = 1'b1;
         ST_CLR_VIS: cmd.vis_clear = 1'b1;
         ST_SEED: cmd.seed = 1'b1;
         ST_EXIT_RD: cmd.exit_rd = 1'b1;
         ST_EDGE_RD: cmd.edge_rd = 1'b1;
         ST_EDGE_CHK: begin
            cmd.edge_chk = 1'b1;
            cmd.level_start = sts.d_last && sts.from_src;
         end
         ST_POP_RD: cmd.pop_rd = !sts.queue_empty;
         ST_POP_DATA: cmd.pop_take = !sts.hit;
         ST_RSP_FOUND: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.rsp_kind = STS_FOUND;
         end
         ST_RSP_ALREADY: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.rsp_kind = STS_ALREADY;
         end
         ST_RSP_NONE: begin
            cmd.rsp_load = sts.rsp_free;
            cmd.rsp_kind = STS_NO_PATH;
         end
         default: cmd = '0;
      endcase
   end

endmodule

@@ hdl/bfsfs_datapath.sv @@
// graph memories, search queue, counters and result register
module bfsfs_datapath import bfsfs_pkg::*; #(
   parameter int ROOMS = ROOMS_DEF,
   parameter int DIRS = DIRS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_action,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   localparam int NODE_W = $clog2(ROOMS);
   localparam int EXITS = ROOMS * DIRS;
   localparam int EXIT_W = (EXITS > 2) ? $clog2(EXITS) : 1;
   localparam int PTR_W = $clog2(ROOMS + 1);

   // request fields
   logic [7:0] f_node, f_dest, f_target;
   logic [3:0] f_dir;
   logic [1:0] f_mode;
   assign f_node = req_tdata[7:0];
   assign f_dir = req_tdata[11:8];
   assign f_dest = req_tdata[19:12];
   assign f_target = req_tdata[32:25];
   assign f_mode = req_tdata[34:33];

   logic [9:0]  exit_mem [EXITS];
   logic [2:0]  flag_mem [ROOMS];
   logic        vis_mem [ROOMS];
   logic [NODE_W+3:0] queue_mem [ROOMS];

   logic [7:0] src_ff, tgt_ff;
   logic god_ff, psi_ff, dist_ff;
   logic [EXIT_W-1:0] cnt_ff, base_ff;
   logic [3:0] d_ff, cur_fd_ff;
   logic from_src_ff;
   logic [PTR_W-1:0] head_ff, tail_ff, lend_ff, level_ff;
   logic [9:0] exit_q;
   logic [2:0] flag_q;
   logic vis_q;
   logic [NODE_W-1:0] qnode_q;
   logic [3:0] qfd_q;
   logic rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [3:0] rsp_dir_ff;
   logic [9:0] rsp_hop_ff;

   logic node_ok, dir_ok, to_ok, push;
   logic [7:0] to_node;
   logic [NODE_W-1:0] to_idx, src_idx;
   logic [3:0] push_fd;
   logic [PTR_W-1:0] tail_in;

   assign node_ok = 32'(f_node) < ROOMS;
   assign dir_ok = 32'(f_dir) < DIRS;
   assign to_node = exit_q[7:0];
   assign to_ok = 32'(to_node) < ROOMS;
   assign to_idx = NODE_W'(32'(to_node));
   assign src_idx = NODE_W'(32'(src_ff));
   assign push_fd = from_src_ff ? d_ff : cur_fd_ff;

   // exit present, open, in range, unvisited, mode allows it, queue not full
   assign push = cmd.edge_chk && exit_q[8] && !exit_q[9] && to_ok && !vis_q
      && !(psi_ff && flag_q[2]) && (god_ff || flag_q[1:0] == 2'b00)
      && 32'(tail_ff) < ROOMS;
   assign tail_in = cmd.seed ? '0 : (push ? tail_ff + PTR_W'(1) : tail_ff);

   // exit memory
   logic exit_we;
   logic [EXIT_W-1:0] exit_wa, exit_ra;
   logic [9:0] exit_wd;
   assign exit_we = cmd.mem_clear || (cmd.wr_exit && node_ok && dir_ok);
   assign exit_wa = cmd.mem_clear ? cnt_ff
      : EXIT_W'(32'(f_node) * DIRS + 32'(f_dir));
   assign exit_wd = cmd.mem_clear ? '0 : {req_tdata[21], req_tdata[20], f_dest};
   assign exit_ra = base_ff + EXIT_W'(d_ff);

   always_ff @(posedge clock) begin
      if (exit_we) exit_mem[exit_wa] <= exit_wd;
      if (cmd.exit_rd) exit_q <= exit_mem[exit_ra];
   end

   // node flags
   logic flag_we;
   logic [NODE_W-1:0] flag_wa;
   assign flag_we = (cmd.mem_clear && 32'(cnt_ff) < ROOMS) || (cmd.wr_flags && node_ok);
   assign flag_wa = cmd.mem_clear ? NODE_W'(cnt_ff) : NODE_W'(32'(f_node));

   always_ff @(posedge clock) begin
      if (flag_we) flag_mem[flag_wa] <= cmd.mem_clear ? 3'b000 : req_tdata[24:22];
      if (cmd.edge_rd) flag_q <= flag_mem[to_idx];
   end

   // visited map
   logic vis_we;
   logic [NODE_W-1:0] vis_wa;
   assign vis_we = cmd.vis_clear || cmd.seed || push;
   assign vis_wa = cmd.vis_clear ? NODE_W'(cnt_ff) : (cmd.seed ? src_idx : to_idx);

   always_ff @(posedge clock) begin
      if (vis_we) vis_mem[vis_wa] <= !cmd.vis_clear;
      if (cmd.edge_rd) vis_q <= vis_mem[to_idx];
   end

   // search queue
   always_ff @(posedge clock) begin
      if (push) queue_mem[tail_ff[NODE_W-1:0]] <= {to_idx, push_fd};
      if (cmd.pop_rd) {qnode_q, qfd_q} <= queue_mem[head_ff[NODE_W-1:0]];
   end

   // query registers and walk state
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff <= f_node;
         tgt_ff <= f_target;
         dist_ff <= (req_action == ACT_DISTANCE);
         god_ff <= (req_action == ACT_DISTANCE) || (f_mode == MODE_GOD);
         psi_ff <= (req_action != ACT_DISTANCE) && (f_mode == MODE_PSIONIC);
      end
      if (cmd.seed) begin
         base_ff <= EXIT_W'(32'(src_idx) * DIRS);
      end else if (cmd.pop_take) begin
         base_ff <= EXIT_W'(32'(qnode_q) * DIRS);
      end
      if (cmd.pop_take) cur_fd_ff <= qfd_q;
      if (cmd.seed || cmd.pop_take) begin
         d_ff <= '0;
      end else if (cmd.edge_chk) begin
         d_ff <= d_ff + 4'd1;
      end
      if (cmd.level_start) begin
         level_ff <= PTR_W'(1);
         lend_ff <= tail_in;
      end else if (cmd.pop_rd && head_ff == lend_ff) begin
         level_ff <= level_ff + PTR_W'(1);
         lend_ff <= tail_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         from_src_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cnt_clear) begin
            cnt_ff <= '0;
         end else if (cmd.mem_clear || cmd.vis_clear) begin
            cnt_ff <= cnt_ff + EXIT_W'(1);
         end
         if (cmd.seed) begin
            head_ff <= '0;
         end else if (cmd.pop_take) begin
            head_ff <= head_ff + PTR_W'(1);
         end
         tail_ff <= tail_in;
         if (cmd.seed) begin
            from_src_ff <= 1'b1;
         end else if (cmd.pop_take) begin
            from_src_ff <= 1'b0;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_dir_ff <= '0;
         rsp_hop_ff <= '0;
         unique case (cmd.rsp_kind)
            STS_FOUND: begin
               if (dist_ff && 32'(level_ff) >= HOP_LIMIT) begin
                  rsp_status_ff <= STS_NO_PATH;
               end else begin
                  rsp_status_ff <= STS_FOUND;
                  rsp_dir_ff <= qfd_q;
                  rsp_hop_ff <= dist_ff ? 10'(32'(level_ff)) : '0;
               end
            end
            STS_ALREADY: rsp_status_ff <= STS_ALREADY;
            default: rsp_status_ff <= STS_NO_PATH;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser = rsp_status_ff;
   assign rsp_tdata = {2'b00, rsp_hop_ff, rsp_dir_ff};

   assign sts.mem_last = 32'(cnt_ff) == EXITS - 1;
   assign sts.vis_last = 32'(cnt_ff) == ROOMS - 1;
   assign sts.same = src_ff == tgt_ff;
   assign sts.range_bad = 32'(src_ff) >= ROOMS || 32'(tgt_ff) >= ROOMS;
   assign sts.d_last = 32'(d_ff) == DIRS - 1;
   assign sts.from_src = from_src_ff;
   assign sts.queue_empty = head_ff == tail_ff;
   assign sts.hit = 32'(qnode_q) == 32'(tgt_ff);
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

endmodule

@@ hdl/bfs_first_step_finder.sv @@
// top level of the breadth-first first-step finder
//
// requests come in on req_* and carry a kind in req_tuser: exit write,
// node flag write, first-step query or distance query. writes give no
// response. each query gives one response on rsp_* with the status in
// rsp_tuser and first direction and hop count in rsp_tdata. a query
// whose source and target differ and are in range clears the visited
// map, then runs a breadth-first search that reads each exit of every
// dequeued node, then the flags and visited bit of the room it leads
// to, and checks that exit, one exit after another. a distance query
// searches in god mode and returns the depth at which the target was
// dequeued. one request is worked on at a time; a new request is taken
// while the previous response still waits in the output register, and a
// stalled receiver holds the search only at its end. after reset the
// exit and flag memories are swept to zero, during which req_tready
// stays low.
module bfs_first_step_finder import bfsfs_pkg::*; #(
   parameter int ROOMS = ROOMS_DEF,
   parameter int DIRS = DIRS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // node[7:0] direction[11:8] dest_node[19:12] exit_present[20]
   // exit_closed[21] no_track[22] death_trap[23] no_psionics[24]
   // target_node[32:25] mode[34:33], zero padding above
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // first_dir[3:0] hop_count[13:4], zero padding above
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]            rsp_tuser
);

   cmd_type cmd;
   sts_type sts;

   bfsfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .sts        (sts),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   bfsfs_datapath #(
      .ROOMS (ROOMS),
      .DIRS  (DIRS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_action (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the breadth-first first-step finder
`timescale 1ns / 1ps

module tb_top;
   import bfsfs_pkg::*;

   localparam int NODES = ROOMS_DEF;
   localparam int EXITS = DIRS_DEF;
   localparam int RANDOM_ITEMS = 206;
   localparam int IDLE_LIMIT = 40000;
   localparam logic [1:0] MODE_STD = 2'd0;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int FOUND_NONE = -2;
   localparam int FOUND_ALREADY = -1;

   typedef struct {
      action_type act;
      logic [7:0] node;
      logic [3:0] dir;
      logic [7:0] dest;
      logic       present;
      logic       closed;
      logic       no_track;
      logic       death;
      logic       no_psi;
      logic [7:0] target;
      logic [1:0] mode;
      bit         fixed;
      status_type st;
      logic [3:0] fdir;
      logic [9:0] hops;
   } request_type;

   typedef struct {
      status_type st;
      logic [3:0] fdir;
      logic [9:0] hops;
   } answer_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // graph copy kept by the predictor
   logic [7:0] exit_dest [NODES*EXITS];
   logic [1:0] exit_state [NODES*EXITS];
   logic [2:0] room_flags [NODES];
   bit         seen [NODES];
   int         bfs_node [NODES];
   int         bfs_dir [NODES];

   answer_type  pending_answers[$];
   int          errors = 0;
   int          sent = 0;
   bit          hold_done = 1'b0;
   int          idle_cycles = 0;
   request_type directed [$];

   bfs_first_step_finder i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int crossable(int room, int d, logic [1:0] mode);
      int idx;
      int to;
      idx = room * EXITS + d;
      to = exit_dest[idx];
      if (!exit_state[idx][0] || seen[to] || exit_state[idx][1]) return -1;
      if (mode == MODE_PSIONIC && room_flags[to][2]) return -1;
      if (mode == MODE_GOD) return to;
      if (room_flags[to][1:0] != 0) return -1;
      return to;
   endfunction

   function automatic int first_step(int src, int dst, logic [1:0] mode);
      int head;
      int tail;
      int to;
      int n;
      if (src == dst) return FOUND_ALREADY;
      foreach (seen[i]) seen[i] = 1'b0;
      head = 0;
      tail = 0;
      seen[src] = 1'b1;
      for (int d = 0; d < EXITS; d++) begin
         to = crossable(src, d, mode);
         if (to >= 0) begin
            seen[to] = 1'b1;
            bfs_node[tail] = to;
            bfs_dir[tail] = d;
            tail++;
         end
      end
      while (head < tail) begin
         n = bfs_node[head];
         if (n == dst) return bfs_dir[head];
         for (int d = 0; d < EXITS; d++) begin
            to = crossable(n, d, mode);
            if (to >= 0 && tail < NODES) begin
               seen[to] = 1'b1;
               bfs_node[tail] = to;
               bfs_dir[tail] = bfs_dir[head];
               tail++;
            end
         end
         head++;
      end
      return FOUND_NONE;
   endfunction

   // applies a request to the graph copy and returns its answer, if any
   function automatic bit predict(request_type r, output answer_type a);
      int res;
      int first;
      int cur;
      int steps;
      a = '{STS_FOUND, 4'd0, 10'd0};
      case (r.act)
         ACT_WRITE_EXIT: begin
            if (r.dir < EXITS) begin
               exit_dest[r.node*EXITS + r.dir] = r.dest;
               exit_state[r.node*EXITS + r.dir] = {r.closed, r.present};
            end
            return 1'b0;
         end
         ACT_WRITE_FLAGS: begin
            room_flags[r.node] = {r.no_psi, r.death, r.no_track};
            return 1'b0;
         end
         ACT_FIRST_STEP: begin
            res = first_step(r.node, r.target, r.mode);
            if (res == FOUND_ALREADY) a.st = STS_ALREADY;
            else if (res < 0) a.st = STS_NO_PATH;
            else a.fdir = 4'(res);
         end
         default: begin
            cur = r.node;
            steps = 0;
            res = first_step(cur, r.target, MODE_GOD);
            first = res;
            if (res == FOUND_ALREADY) begin
               a.st = STS_ALREADY;
               return 1'b1;
            end
            while (res >= 0 && steps < HOP_LIMIT) begin
               cur = exit_dest[cur*EXITS + res];
               steps++;
               res = first_step(cur, r.target, MODE_GOD);
            end
            if (cur != r.target || steps >= HOP_LIMIT || first < 0) begin
               a.st = STS_NO_PATH;
            end else begin
               a.fdir = 4'(first);
               a.hops = 10'(steps);
            end
         end
      endcase
      return 1'b1;
   endfunction

   function automatic request_type mk(action_type act, int node, int dir, int dest,
                                      bit pres, bit clo, bit nt, bit dt, bit np,
                                      int tgt, logic [1:0] mode, bit fixed = 1'b0,
                                      status_type st = STS_FOUND, int fdir = 0,
                                      int hops = 0);
      request_type r;
      r = '{act, 8'(node), 4'(dir), 8'(dest), pres, clo, nt, dt, np, 8'(tgt), mode,
            fixed, st, 4'(fdir), 10'(hops)};
      return r;
   endfunction

   function automatic int short_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic request_type random_request();
      request_type r;
      int p;
      int span;
      p = $urandom_range(0, 99);
      span = ($urandom_range(0, 9) == 0) ? 255 : 15;
      r = mk(ACT_WRITE_EXIT, $urandom_range(0, span), $urandom_range(0, 9),
             $urandom_range(0, span), $urandom_range(0, 99) < 85,
             $urandom_range(0, 99) < 12, 0, 0, 0, $urandom_range(0, 255),
             2'($urandom_range(0, 3)));
      // keep the graph mostly open, with the odd unused field bit set
      r.no_track = $urandom_range(0, 99) < 8;
      r.death = $urandom_range(0, 99) < 8;
      r.no_psi = $urandom_range(0, 99) < 15;
      if (p < 5) begin
         r.dir = 4'($urandom_range(10, 15));
      end else if (p < 50) begin
      end else if (p < 62) begin
         r.act = ACT_WRITE_FLAGS;
      end else begin
         r.act = (p < 84) ? ACT_FIRST_STEP : ACT_DISTANCE;
         r.target = 8'($urandom_range(0, span));
      end
      return r;
   endfunction

   task automatic send(request_type r);
      answer_type a;
      int gap;
      gap = short_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= r.act;
      req_tdata <= {5'd0, r.mode, r.target, r.no_psi, r.death, r.no_track,
                    r.closed, r.present, r.dest, r.dir, r.node};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (predict(r, a)) begin
         if (r.fixed) pending_answers.push_back('{r.st, r.fdir, r.hops});
         else pending_answers.push_back(a);
      end
   endtask

   // receiver: random stalls, one long hold-off while requests keep coming
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_answers.size() == 0) begin
               report_mismatch("unexpected response", rsp_tuser, -1);
            end else begin
               answer_type e;
               e = pending_answers.pop_front();
               if (rsp_tuser != e.st) report_mismatch("status", rsp_tuser, e.st);
               if (rsp_tdata[3:0] != e.fdir) report_mismatch("first_dir", rsp_tdata[3:0], e.fdir);
               if (rsp_tdata[13:4] != e.hops) report_mismatch("hop_count", rsp_tdata[13:4], e.hops);
               if (rsp_tdata[RSP_DATA_W-1:14] != 0) report_mismatch("padding", rsp_tdata, 0);
            end
         end
         if (!hold_done && sent > 120) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (sent > 60 && sent < 90) begin
            rsp_tready <= 1'b1;
         end else begin
            stall = short_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      foreach (exit_dest[i]) begin
         exit_dest[i] = '0;
         exit_state[i] = '0;
      end
      foreach (room_flags[i]) room_flags[i] = '0;
      directed = '{
         mk(ACT_FIRST_STEP, 3, 0, 0, 0, 0, 0, 0, 0, 3, MODE_STD, 1, STS_ALREADY),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1, MODE_STD, 1, STS_NO_PATH),
         mk(ACT_DISTANCE, 255, 0, 0, 0, 0, 0, 0, 0, 0, MODE_STD, 1, STS_NO_PATH),
         mk(ACT_WRITE_EXIT, 0, 0, 1, 1, 0, 0, 0, 0, 0, MODE_STD),
         mk(ACT_WRITE_EXIT, 1, 9, 2, 1, 0, 0, 0, 0, 0, MODE_STD),
         mk(ACT_WRITE_EXIT, 0, 5, 2, 1, 1, 0, 0, 0, 0, MODE_STD),
         mk(ACT_WRITE_EXIT, 0, 15, 2, 1, 0, 0, 0, 0, 0, MODE_STD),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_STD, 1, STS_FOUND, 0),
         mk(ACT_DISTANCE, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_STD, 1, STS_FOUND, 0, 2),
         mk(ACT_WRITE_FLAGS, 1, 0, 0, 0, 0, 1, 0, 0, 0, MODE_STD),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_STD, 1, STS_NO_PATH),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_GOD, 1, STS_FOUND, 0),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_UNUSED, 1, STS_NO_PATH),
         mk(ACT_WRITE_FLAGS, 1, 0, 0, 0, 0, 0, 0, 1, 0, MODE_STD),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_PSIONIC, 1, STS_NO_PATH),
         mk(ACT_FIRST_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_STD),
         mk(ACT_WRITE_FLAGS, 1, 0, 0, 0, 0, 0, 1, 0, 0, MODE_STD),
         mk(ACT_DISTANCE, 0, 0, 0, 0, 0, 0, 0, 0, 2, MODE_PSIONIC, 1, STS_FOUND, 0, 2),
         mk(ACT_WRITE_EXIT, 2, 3, 255, 1, 0, 0, 0, 0, 0, MODE_STD),
         mk(ACT_WRITE_EXIT, 255, 9, 0, 1, 0, 0, 0, 0, 0, MODE_STD),
         // flags of the source are never looked at
         mk(ACT_WRITE_FLAGS, 255, 0, 0, 0, 0, 1, 1, 1, 0, MODE_STD),
         mk(ACT_FIRST_STEP, 255, 0, 0, 0, 0, 0, 0, 0, 1, MODE_GOD),
         mk(ACT_WRITE_FLAGS, 1, 0, 0, 0, 0, 0, 0, 0, 0, MODE_STD),
         mk(ACT_DISTANCE, 2, 0, 0, 0, 0, 0, 0, 0, 1, MODE_STD)
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send(directed[i]);
      for (int i = 0; i < RANDOM_ITEMS; i++) send(random_request());
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

@@ bfs_first_step_finder.f @@
hdl/bfsfs_pkg.sv
hdl/bfsfs_ctrl.sv
hdl/bfsfs_datapath.sv
hdl/bfs_first_step_finder.sv
tb/sv/tb_top.sv
